### rtl/kbpc_pkg.sv
// Shared constants, types and controller/datapath command structures for the
// keyed block permutation cipher. No dependencies.
`timescale 1ns / 1ps

package kbpc_pkg;

    localparam int KEY_MAX = 8;
    localparam int IDX_W   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CNT_W   = $clog2(KEY_MAX + 1);

    localparam int BYTE_W   = 8;
    localparam int KLEN_W   = 4;
    localparam int KEY_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = KEY_W;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h71;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_KEY_BYTES  = 2'd2
    } cfg_idx_t;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_we;
        idx_t store_addr;
        logic perm_en;
        idx_t perm_idx;
        cnt_t blk_cnt;
        logic out_load;
        idx_t out_idx;
        logic out_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cnt_t blk_len;
        logic mode;
        logic len_written;
    } status_t;

endpackage

### rtl/kbpc_dp.sv
// Datapath of the keyed block permutation cipher: configuration registers,
// block store, rank logic, permuted block buffer and output register.
// Depends on kbpc_pkg.
`timescale 1ns / 1ps

module kbpc_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [kbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kbpc_pkg::CFG_W-1:0]       cfg_data,
    input  logic [kbpc_pkg::BYTE_W-1:0]      data_byte,
    input  kbpc_pkg::cmd_t                   cmd,
    output kbpc_pkg::status_t                status,
    output logic [kbpc_pkg::BYTE_W-1:0]      out_byte,
    output logic                             out_last
);

    logic                              mode_reg;
    logic [kbpc_pkg::KLEN_W-1:0]       klen_reg;
    logic [kbpc_pkg::KEY_W-1:0]        key_reg;

    logic [kbpc_pkg::BYTE_W-1:0]       store_mem [kbpc_pkg::KEY_MAX];
    logic [kbpc_pkg::BYTE_W-1:0]       obuf_mem  [kbpc_pkg::KEY_MAX];
    logic [kbpc_pkg::BYTE_W-1:0]       out_byte_reg;
    logic                              out_last_reg;

    kbpc_pkg::cnt_t                    blk_len;
    kbpc_pkg::cnt_t                    rank_sum;
    kbpc_pkg::idx_t                    rank;
    kbpc_pkg::idx_t                    rd_addr;
    kbpc_pkg::idx_t                    wr_addr;
    logic [kbpc_pkg::BYTE_W-1:0]       key_j;
    logic [kbpc_pkg::BYTE_W-1:0]       key_k;
    logic [kbpc_pkg::BYTE_W-1:0]       perm_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= kbpc_pkg::MODE_ENCRYPT;
            klen_reg <= kbpc_pkg::KLEN_W'(1);
            key_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (kbpc_pkg::cfg_idx_t'(cfg_index))
                kbpc_pkg::CFG_MODE:       mode_reg <= cfg_data[0];
                kbpc_pkg::CFG_KEY_LENGTH: klen_reg <= cfg_data[kbpc_pkg::KLEN_W-1:0];
                kbpc_pkg::CFG_KEY_BYTES:  key_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Block length is the key length clamped into 1..KEY_MAX.
    always_comb
    begin
        if (klen_reg == '0)
            blk_len = kbpc_pkg::cnt_t'(1);
        else if (klen_reg > kbpc_pkg::KLEN_W'(kbpc_pkg::KEY_MAX))
            blk_len = kbpc_pkg::cnt_t'(kbpc_pkg::KEY_MAX);
        else
            blk_len = kbpc_pkg::cnt_t'(klen_reg);
    end

    assign status.blk_len     = blk_len;
    assign status.mode        = mode_reg;
    assign status.len_written = cfg_write &&
                                (kbpc_pkg::cfg_idx_t'(cfg_index) == kbpc_pkg::CFG_KEY_LENGTH);

    // Rank of key position perm_idx: smaller key bytes plus equal ones at lower positions.
    always_comb
    begin
        key_j    = key_reg[cmd.perm_idx * kbpc_pkg::BYTE_W +: kbpc_pkg::BYTE_W];
        rank_sum = '0;
        key_k    = '0;
        for (int k = 0; k < kbpc_pkg::KEY_MAX; k++)
        begin
            key_k = key_reg[k * kbpc_pkg::BYTE_W +: kbpc_pkg::BYTE_W];
            if ((kbpc_pkg::cnt_t'(k) < blk_len) &&
                ((key_k < key_j) ||
                 ((key_k == key_j) && (kbpc_pkg::idx_t'(k) < cmd.perm_idx))))
                rank_sum = rank_sum + kbpc_pkg::cnt_t'(1);
        end
        rank = rank_sum[kbpc_pkg::IDX_W-1:0];
    end

    // Encrypt scatters store[j] to position rank; decrypt gathers store[rank] to j.
    // Positions past the collected count of a short block read as the pad byte.
    always_comb
    begin
        if (mode_reg == kbpc_pkg::MODE_DECRYPT)
        begin
            rd_addr = rank;
            wr_addr = cmd.perm_idx;
        end
        else
        begin
            rd_addr = cmd.perm_idx;
            wr_addr = rank;
        end
        if (kbpc_pkg::cnt_t'(rd_addr) < cmd.blk_cnt)
            perm_data = store_mem[rd_addr];
        else
            perm_data = kbpc_pkg::PAD_BYTE;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
            store_mem[cmd.store_addr] <= data_byte;
        if (cmd.perm_en)
            obuf_mem[wr_addr] <= perm_data;
        if (cmd.out_load)
        begin
            out_byte_reg <= obuf_mem[cmd.out_idx];
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

### rtl/kbpc_ctrl.sv
// Controller of the keyed block permutation cipher: collect, permute and drain
// sequencing, fill count and output valid. Depends on kbpc_pkg.
`timescale 1ns / 1ps

module kbpc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_stall,
    input  kbpc_pkg::status_t   status,
    output kbpc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_PERMUTE = 3'b010,
        S_DRAIN   = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    kbpc_pkg::cnt_t  fill_reg, fill_next;
    kbpc_pkg::cnt_t  cnt_reg, cnt_next;
    kbpc_pkg::idx_t  idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;

    kbpc_pkg::cnt_t  fill_cur;
    kbpc_pkg::cnt_t  fill_inc;
    logic            in_accept;
    logic            idx_at_end;
    logic            out_load;

    assign in_accept  = in_valid && (state_reg == S_COLLECT);
    assign in_stall   = (state_reg != S_COLLECT);
    assign fill_cur   = (fill_reg >= status.blk_len) ? '0 : fill_reg;
    assign fill_inc   = fill_cur + kbpc_pkg::cnt_t'(1);
    assign idx_at_end = (kbpc_pkg::cnt_t'(idx_reg) == (status.blk_len - kbpc_pkg::cnt_t'(1)));
    assign out_load   = (state_reg == S_DRAIN) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_COLLECT:
            begin
                if (in_accept)
                begin
                    if (fill_inc >= status.blk_len)
                    begin
                        fill_next  = '0;
                        cnt_next   = fill_inc;
                        idx_next   = '0;
                        state_next = S_PERMUTE;
                    end
                    else if (end_of_message)
                    begin
                        fill_next = '0;
                        // A short block is padded for encryption and dropped for decryption.
                        if (status.mode == kbpc_pkg::MODE_ENCRYPT)
                        begin
                            cnt_next   = fill_inc;
                            idx_next   = '0;
                            state_next = S_PERMUTE;
                        end
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            S_PERMUTE:
            begin
                idx_next = idx_reg + kbpc_pkg::idx_t'(1);
                if (idx_at_end)
                begin
                    idx_next   = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (out_load)
                begin
                    idx_next = idx_reg + kbpc_pkg::idx_t'(1);
                    if (idx_at_end)
                    begin
                        idx_next   = '0;
                        state_next = S_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase

        // Writing the key length discards a partly collected block.
        if (status.len_written)
            fill_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assign cmd.store_we   = in_accept;
    assign cmd.store_addr = fill_cur[kbpc_pkg::IDX_W-1:0];
    assign cmd.perm_en    = (state_reg == S_PERMUTE);
    assign cmd.perm_idx   = idx_reg;
    assign cmd.blk_cnt    = cnt_reg;
    assign cmd.out_load   = out_load;
    assign cmd.out_idx    = idx_reg;
    assign cmd.out_last   = idx_at_end;

endmodule

### rtl/keyed_block_permutation_cipher_top.sv
// Top level of the keyed block permutation cipher: joins the controller and
// the datapath. Depends on kbpc_pkg, kbpc_ctrl and kbpc_dp.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+----------------------------------
//   input    | in_valid / in_stall (out)    | data_byte, end_of_message
//   output   | out_valid / out_stall (in)   | out_byte, out_last
//   config   | cfg_write                    | cfg_index, cfg_data
//
// A block of n bytes (n = clamped key length) is collected at one byte per cycle,
// permuted into the block buffer at one rank per cycle, then drained through the
// output register at one byte per cycle while out_stall is low. The input is
// stalled while permuting and draining; the last output byte may still wait in the
// output register while collection of the next block starts.
// Reset clears control state and sets mode 0, key length 1 and key bytes 0.
`timescale 1ns / 1ps

module keyed_block_permutation_cipher_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [kbpc_pkg::BYTE_W-1:0]      data_byte,
    input  logic                             end_of_message,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [kbpc_pkg::BYTE_W-1:0]      out_byte,
    output logic                             out_last,
    input  logic                             cfg_write,
    input  logic [kbpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kbpc_pkg::CFG_W-1:0]       cfg_data
);

    kbpc_pkg::cmd_t     cmd;
    kbpc_pkg::status_t  status;

    kbpc_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .cmd            (cmd)
    );

    kbpc_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_byte (data_byte),
        .cmd       (cmd),
        .status    (status),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

### dv/testbench.sv
// Self-checking testbench for keyed_block_permutation_cipher_top: directed and random byte
// streams with randomized backpressure, checked against an in-line block permutation predictor.
// Depends on kbpc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF     = 6;
    localparam int CLK_PERIOD   = 2 * CLK_HALF;
    // Collect, permute and drain of the largest block, with margin.
    localparam int DRAIN_CYCLES = 3 * kbpc_pkg::KEY_MAX + 16;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic [kbpc_pkg::BYTE_W-1:0] value;
        logic                        last;
    } cipher_out_t;

    logic                           clk;
    logic                           rst_n          = 1'b0;
    logic                           in_valid       = 1'b0;
    logic                           in_stall;
    logic [kbpc_pkg::BYTE_W-1:0]    data_byte      = '0;
    logic                           end_of_message = 1'b0;
    logic                           out_valid;
    logic                           out_stall      = 1'b0;
    logic [kbpc_pkg::BYTE_W-1:0]    out_byte;
    logic                           out_last;
    logic                           cfg_write      = 1'b0;
    logic [kbpc_pkg::CFG_IDX_W-1:0] cfg_index      = '0;
    logic [kbpc_pkg::CFG_W-1:0]     cfg_data       = '0;

    // Predictor state: register copies plus the block being collected.
    logic                           pred_mode;
    logic [kbpc_pkg::KLEN_W-1:0]    pred_key_len;
    logic [kbpc_pkg::KEY_W-1:0]     pred_key;
    logic [kbpc_pkg::BYTE_W-1:0]    pred_block [kbpc_pkg::KEY_MAX];
    int                             pred_fill;

    cipher_out_t          expected_cipher_q [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int bytes_sent      = 0;
    int bytes_checked   = 0;
    int blocks_emitted  = 0;
    int blocks_padded   = 0;
    int blocks_dropped  = 0;
    int config_writes   = 0;

    keyed_block_permutation_cipher_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    function automatic int block_len();
        if (pred_key_len == 0)
            return 1;
        if (pred_key_len > kbpc_pkg::KEY_MAX)
            return kbpc_pkg::KEY_MAX;
        return int'(pred_key_len);
    endfunction

    // Rank of a key position is the count of smaller key bytes plus equal ones earlier on.
    function automatic void emit_permuted_block(input int n);
        logic [kbpc_pkg::BYTE_W-1:0] permuted [kbpc_pkg::KEY_MAX];
        logic [kbpc_pkg::BYTE_W-1:0] kj;
        logic [kbpc_pkg::BYTE_W-1:0] kk;
        int                          r;
        cipher_out_t                 e;
        for (int j = 0; j < n; j++)
        begin
            kj = pred_key[8*j +: 8];
            r  = 0;
            for (int k = 0; k < n; k++)
            begin
                kk = pred_key[8*k +: 8];
                if (kk < kj || (kk == kj && k < j))
                    r++;
            end
            if (pred_mode == kbpc_pkg::MODE_DECRYPT)
                permuted[j] = pred_block[r];
            else
                permuted[r] = pred_block[j];
        end
        for (int j = 0; j < n; j++)
        begin
            e.value = permuted[j];
            e.last  = (j == n - 1);
            expected_cipher_q.push_back(e);
        end
        blocks_emitted++;
    endfunction

    function automatic void predict_cipher_byte(input logic [kbpc_pkg::BYTE_W-1:0] b,
                                                input logic eom);
        int n;
        n = block_len();
        if (pred_fill >= n)
            pred_fill = 0;
        pred_block[pred_fill] = b;
        pred_fill++;
        if (pred_fill >= n)
        begin
            pred_fill = 0;
            emit_permuted_block(n);
        end
        else if (eom)
        begin
            if (pred_mode == kbpc_pkg::MODE_DECRYPT)
            begin
                blocks_dropped++;
            end
            else
            begin
                for (int i = pred_fill; i < n; i++)
                    pred_block[i] = kbpc_pkg::PAD_BYTE;
                blocks_padded++;
                emit_permuted_block(n);
            end
            pred_fill = 0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_cipher_byte(input logic [kbpc_pkg::BYTE_W-1:0] b, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        data_byte      = b;
        end_of_message = eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_cipher_byte(b, eom);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Holds the sender off until every expected byte has arrived and the block has settled.
    task automatic wait_until_idle();
        in_valid = 1'b0;
        while (expected_cipher_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input kbpc_pkg::cfg_idx_t idx,
                                input logic [kbpc_pkg::CFG_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            kbpc_pkg::CFG_MODE:
                pred_mode = value[0];
            kbpc_pkg::CFG_KEY_LENGTH:
            begin
                pred_key_len = value[kbpc_pkg::KLEN_W-1:0];
                pred_fill    = 0;
            end
            kbpc_pkg::CFG_KEY_BYTES:
                pred_key = value;
            default:
                ;
        endcase
        config_writes++;
    endtask

    function automatic logic [kbpc_pkg::KEY_W-1:0] random_key();
        logic [kbpc_pkg::KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0:
                for (int i = 0; i < kbpc_pkg::KEY_MAX; i++)
                    k[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
            1:
                for (int i = 0; i < kbpc_pkg::KEY_MAX; i++)
                    k[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:
                k = {$urandom(), $urandom()};
        endcase
        return k;
    endfunction

    function automatic logic [kbpc_pkg::KLEN_W-1:0] random_key_len();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd8;
            3:       return 4'd1;
            4:       return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(2, 8));
        endcase
    endfunction

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cipher_out_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_cipher_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last=%0b", out_byte, out_last));
            end
            else
            begin
                want = expected_cipher_q.pop_front();
                if (out_byte !== want.value)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.value));
                if (out_last !== want.last)
                    report_mismatch($sformatf("out_last %0b, expected %0b",
                                              out_last, want.last));
                bytes_checked++;
            end
        end
    end

    // Reset values: mode encrypt, key length one, so every byte comes straight back.
    task automatic test_reset_defaults();
        send_cipher_byte(8'h00, 1'b0);
        send_cipher_byte(8'hFF, 1'b1);
    endtask

    task automatic test_encrypt_extremes();
        wait_until_idle();
        write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'(kbpc_pkg::MODE_ENCRYPT));
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(8));
        write_config(kbpc_pkg::CFG_KEY_BYTES, 64'h617A_6162_7A00_FF61);
        send_cipher_byte(8'h00, 1'b0);
        send_cipher_byte(8'hFF, 1'b0);
        send_cipher_byte(8'h80, 1'b0);
        send_cipher_byte(8'h7F, 1'b0);
        send_cipher_byte(8'h01, 1'b0);
        send_cipher_byte(8'hFE, 1'b0);
        send_cipher_byte(8'h55, 1'b0);
        send_cipher_byte(8'hAA, 1'b0);
        // A single-byte final block is padded out to the full length.
        send_cipher_byte(8'h5A, 1'b1);
    endtask

    task automatic test_decrypt_blocks();
        wait_until_idle();
        write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'(kbpc_pkg::MODE_DECRYPT));
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(4));
        write_config(kbpc_pkg::CFG_KEY_BYTES, 64'h0000_0000_0301_0401);
        // End of message on the byte that fills the block emits it normally.
        send_cipher_byte(8'h11, 1'b0);
        send_cipher_byte(8'h22, 1'b0);
        send_cipher_byte(8'h33, 1'b0);
        send_cipher_byte(8'h44, 1'b1);
        wait_until_idle();
        // A short trailing block in decrypt mode produces nothing.
        send_cipher_byte(8'hC3, 1'b0);
        send_cipher_byte(8'h3C, 1'b1);
    endtask

    task automatic test_length_clamp();
        wait_until_idle();
        write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'(kbpc_pkg::MODE_ENCRYPT));
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(0));
        send_cipher_byte(8'h96, 1'b0);
        wait_until_idle();
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(15));
        write_config(kbpc_pkg::CFG_KEY_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cipher_byte(8'h01, 1'b0);
        send_cipher_byte(8'h02, 1'b0);
        send_cipher_byte(8'h03, 1'b1);
    endtask

    task automatic test_midblock_writes();
        wait_until_idle();
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(3));
        write_config(kbpc_pkg::CFG_KEY_BYTES, 64'h0000_0000_0010_2030);
        send_cipher_byte(8'hA1, 1'b0);
        // Mode and key changed with one byte collected take effect at emission.
        wait_until_idle();
        write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'(kbpc_pkg::MODE_DECRYPT));
        write_config(kbpc_pkg::CFG_KEY_BYTES, 64'h0000_0000_0030_1020);
        send_cipher_byte(8'hB2, 1'b0);
        send_cipher_byte(8'hC3, 1'b0);
        send_cipher_byte(8'hD4, 1'b0);
        // Writing the key length throws the partial block away.
        wait_until_idle();
        write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(5));
        write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'(kbpc_pkg::MODE_ENCRYPT));
        send_cipher_byte(8'hE5, 1'b1);
    endtask

    task automatic run_random_phase(input int items, input int send_pct, input int recv_pct);
        int sent;
        int n;
        int msg_len;
        bit noisy;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < items)
        begin
            wait_until_idle();
            write_config(kbpc_pkg::CFG_MODE, kbpc_pkg::CFG_W'($urandom_range(0, 1)));
            write_config(kbpc_pkg::CFG_KEY_LENGTH, kbpc_pkg::CFG_W'(random_key_len()));
            write_config(kbpc_pkg::CFG_KEY_BYTES, random_key());
            n = block_len();
            repeat ($urandom_range(2, 4))
            begin
                msg_len = $urandom_range(1, 2 * n + 1);
                noisy   = ($urandom_range(0, 7) == 0);
                for (int i = 0; i < msg_len; i++)
                begin
                    if (noisy)
                        send_cipher_byte(8'($urandom()), 1'($urandom_range(0, 3) == 0));
                    else
                        send_cipher_byte(8'($urandom()), i == msg_len - 1);
                    sent++;
                end
                if ($urandom_range(0, 5) == 0)
                    wait_until_idle();
            end
        end
    endtask

    // Each phase overshoots its target by part of one configuration round.
    task automatic test_random_traffic();
        run_random_phase(36, 0, 0);
        run_random_phase(36, 66, 0);
        run_random_phase(36, 0, 66);
        run_random_phase(36, 37, 37);
    endtask

    initial
    begin
        pred_mode    = kbpc_pkg::MODE_ENCRYPT;
        pred_key_len = 4'd1;
        pred_key     = '0;
        pred_fill    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_encrypt_extremes();
        test_decrypt_blocks();
        test_length_clamp();
        test_midblock_writes();
        test_random_traffic();

        wait_until_idle();
        $display("Sent %0d bytes and checked %0d output bytes across %0d register writes.",
                 bytes_sent, bytes_checked, config_writes);
        $display("Blocks emitted: %0d (%0d padded); short decrypt blocks dropped: %0d.",
                 blocks_emitted, blocks_padded, blocks_dropped);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Timed out with %0d output bytes still expected.", expected_cipher_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
